>>> sv/bks_pkg.sv
// ----------------------------------------------------------------------------
// Batch key sorter package
// Shared widths, default parameter values and control types of the sorter.
// ----------------------------------------------------------------------------
package bks_pkg;

    localparam int KEY_PORT_W    = 32;
    localparam int TAG_W         = 6;
    localparam int DEF_MAX_ITEMS = 64;
    localparam int DEF_KEY_BITS  = 32;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;   // place the incoming item in sorted position
        logic shift;    // move every entry one cell towards the head
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } sort_state_t;

endpackage

>>> sv/bks_cell.sv
// ----------------------------------------------------------------------------
// Sorter cell
// One slot of the insertion chain: holds one entry and trades with its
// neighbours on insert and on shift-out.
// ----------------------------------------------------------------------------
module bks_cell
    import bks_pkg::*;
#(
    parameter int KEY_W = DEF_KEY_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] new_key,
    input  logic [TAG_W-1:0] new_tag,
    input  logic             left_move,
    input  logic             left_valid,
    input  logic [KEY_W-1:0] left_key,
    input  logic [TAG_W-1:0] left_tag,
    input  logic             right_valid,
    input  logic [KEY_W-1:0] right_key,
    input  logic [TAG_W-1:0] right_tag,
    output logic             valid,
    output logic [KEY_W-1:0] key,
    output logic [TAG_W-1:0] tag,
    output logic             move
);

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;

    // A strictly greater key gives way, so equal keys keep their load order.
    assign move = !valid_reg || (key_reg > new_key);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        if (ctrl.shift)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            tag_next   = right_tag;
        end
        else if (ctrl.insert)
        begin
            // An empty left neighbour hands on an empty slot.
            if (left_move)
            begin
                valid_next = left_valid;
                key_next   = left_key;
                tag_next   = left_tag;
            end
            else if (move)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                tag_next   = new_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign tag   = tag_reg;

endmodule

>>> sv/batch_key_sorter.sv
// ----------------------------------------------------------------------------
// Batch key sorter
// Loads a batch of keyed records into a chain of insertion cells and emits
// them in ascending key order, equal keys in load order.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  input     start & !busy          sort_key, record_tag, batch_end
//  result    result_strobe          sorted_key, sorted_tag, final_flag,
//                                   overflow
//
// While a batch loads, one item is taken every cycle: the item is placed in
// sorted position across the cell chain in the cycle it is accepted.
// After the item marked batch_end, busy rises and the chain shifts one
// record per cycle towards its head, so each record stored in the batch
// yields one result, the results following on consecutive cycles; each
// is registered from the head cell.
// busy falls with the final result, and the next batch may start then.
// Reset empties every cell and clears the fill count and the dropped-record flag behind overflow.
// The receiver cannot stall the results; they are emitted without pause.
//
module batch_key_sorter
    import bks_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS,
    parameter int KEY_BITS  = DEF_KEY_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [KEY_PORT_W-1:0] sort_key,
    input  logic [TAG_W-1:0]      record_tag,
    input  logic                  batch_end,
    output logic                  result_strobe,
    output logic [KEY_PORT_W-1:0] sorted_key,
    output logic [TAG_W-1:0]      sorted_tag,
    output logic                  final_flag,
    output logic                  overflow
);

    // Only the low KEY_BITS of the key port take part in the ordering.
    localparam int KEY_W   = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int COUNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_ITEMS);
    localparam logic [COUNT_W-1:0] ONE_COUNT  = COUNT_W'(1);

    sort_state_t           state_reg;
    sort_state_t           state_next;
    logic [COUNT_W-1:0]    fill_reg;
    logic [COUNT_W-1:0]    fill_next;
    logic                  dropped_reg;
    logic                  dropped_next;

    logic                  strobe_reg;
    logic [KEY_PORT_W-1:0] key_out_reg;
    logic [TAG_W-1:0]      tag_out_reg;
    logic                  final_reg;
    logic                  overflow_reg;

    logic                  accept;
    logic                  full;
    logic                  draining;
    cell_ctrl_t            ctrl;
    logic [KEY_W-1:0]      new_key;

    logic                  cell_valid [MAX_ITEMS];
    logic [KEY_W-1:0]      cell_key   [MAX_ITEMS];
    logic [TAG_W-1:0]      cell_tag   [MAX_ITEMS];
    logic                  cell_move  [MAX_ITEMS];

    assign draining = (state_reg == ST_DRAIN);
    assign busy     = draining;
    assign accept   = start && !busy;
    assign full     = (fill_reg == FULL_COUNT);
    assign new_key  = sort_key[KEY_W-1:0];

    // Records beyond capacity are dropped but still close the batch.
    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = draining;

    // The chain: each cell sees its left neighbour on insert and its right
    // neighbour on shift-out. Empty cells shift in from beyond the tail.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic             l_move;
        logic             l_valid;
        logic [KEY_W-1:0] l_key;
        logic [TAG_W-1:0] l_tag;
        logic             r_valid;
        logic [KEY_W-1:0] r_key;
        logic [TAG_W-1:0] r_tag;

        if (i == 0)
        begin : g_head
            assign l_move  = 1'b0;
            assign l_valid = 1'b0;
            assign l_key   = '0;
            assign l_tag   = '0;
        end
        else
        begin : g_body
            assign l_move  = cell_move[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_key   = cell_key[i-1];
            assign l_tag   = cell_tag[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_key   = '0;
            assign r_tag   = '0;
        end
        else
        begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_key   = cell_key[i+1];
            assign r_tag   = cell_tag[i+1];
        end

        bks_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_key     (new_key),
            .new_tag     (record_tag),
            .left_move   (l_move),
            .left_valid  (l_valid),
            .left_key    (l_key),
            .left_tag    (l_tag),
            .right_valid (r_valid),
            .right_key   (r_key),
            .right_tag   (r_tag),
            .valid       (cell_valid[i]),
            .key         (cell_key[i]),
            .tag         (cell_tag[i]),
            .move        (cell_move[i])
        );
    end

    // Batch control. During the drain the fill count counts the records
    // still to leave, so it returns to zero as the batch finishes.
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + ONE_COUNT;
                    end
                    if (batch_end)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                fill_next = fill_reg - ONE_COUNT;
                if (fill_reg == ONE_COUNT)
                begin
                    state_next   = ST_LOAD;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            final_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
            strobe_reg  <= draining;
            final_reg   <= draining && (fill_reg == ONE_COUNT);
        end
    end

    // The head cell holds the smallest remaining record during the drain.
    always_ff @(posedge clk)
    begin
        key_out_reg  <= KEY_PORT_W'(cell_key[0]);
        tag_out_reg  <= cell_tag[0];
        overflow_reg <= dropped_reg;
    end

    assign result_strobe = strobe_reg;
    assign sorted_key    = key_out_reg;
    assign sorted_tag    = tag_out_reg;
    assign final_flag    = final_reg;
    assign overflow      = overflow_reg;

`ifndef SYNTHESIS
    a_strobe_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == ST_DRAIN))
        else $error("result emitted without a drain cycle");

    a_final_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        final_flag |-> result_strobe)
        else $error("final flag without a result");

    a_idle_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && final_flag) |-> !busy)
        else $error("still busy after the final result");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("fill count beyond capacity");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("drain from an empty head cell");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Batch key sorter testbench
// Loads batches of keyed records through the start/busy handshake, predicts
// the stably sorted output of every closed batch and checks each strobed
// result against it, field by field and in order.
// ----------------------------------------------------------------------------
module testbench;
    import bks_pkg::*;

    localparam int SORT_DEPTH   = DEF_MAX_ITEMS;
    localparam int KEY_WIDTH    = DEF_KEY_BITS;
    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 150;
    localparam int IDLE_PERCENT = 31;
    localparam int REPORT_LIMIT = 10;
    // Quiet cycles after the last expected result, to catch stray strobes.
    localparam int DRAIN_SLACK  = SORT_DEPTH + 8;
    localparam int RUN_LIMIT_CYCLES = 200000;

    // Only the low KEY_WIDTH bits of a key take part in the ordering.
    localparam bit [63:0] KEY_MASK = (KEY_WIDTH >= 64) ? {64{1'b1}}
                                                        : ((64'd1 << KEY_WIDTH) - 64'd1);

    // Flavours of key for the random batches.
    typedef enum int {
        KEYS_SPREAD,
        KEYS_CLUSTERED,
        KEYS_EXTREME
    } key_mix_t;

    // One record waiting to be loaded, with its pacing hints for the driver.
    typedef struct {
        bit [KEY_PORT_W-1:0] key;
        bit [TAG_W-1:0]      tag;
        bit                  closes;
        bit                  hush;     // no random gap in front of this item
        bit                  settle;   // hold back until every result is out
    } load_item_t;

    // One record as it should leave the sorter.
    typedef struct {
        bit [KEY_PORT_W-1:0] key;
        bit [TAG_W-1:0]      tag;
        bit                  closes;
        bit                  dropped;
    } sorted_rec_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic [KEY_PORT_W-1:0] sort_key   = '0;
    logic [TAG_W-1:0]      record_tag = '0;
    logic                  batch_end  = 1'b0;
    logic                  busy;
    logic                  result_strobe;
    logic [KEY_PORT_W-1:0] sorted_key;
    logic [TAG_W-1:0]      sorted_tag;
    logic                  final_flag;
    logic                  overflow;

    load_item_t          load_queue[$];
    sorted_rec_t         sorted_due[$];

    // Shadow of the open batch inside the sorter.
    bit [KEY_PORT_W-1:0] held_keys[$];
    bit [TAG_W-1:0]      held_tags[$];
    bit                  batch_dropped = 1'b0;

    int items_total     = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int batches_closed  = 0;
    int batches_dropped = 0;
    int faults          = 0;

    batch_key_sorter #(
        .MAX_ITEMS (SORT_DEPTH),
        .KEY_BITS  (KEY_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sort_key      (sort_key),
        .record_tag    (record_tag),
        .batch_end     (batch_end),
        .result_strobe (result_strobe),
        .sorted_key    (sorted_key),
        .sorted_tag    (sorted_tag),
        .final_flag    (final_flag),
        .overflow      (overflow)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Takes one accepted record into the open batch. A record that finds the
    // batch full is thrown away and marks the batch as overflowed. On the
    // closing record the batch is sorted with equal keys kept in load order,
    // and one expected result per stored record is queued.
    function automatic void absorb_record(logic [KEY_PORT_W-1:0] key,
                                          logic [TAG_W-1:0] tag, logic closes);
        bit [KEY_PORT_W-1:0] order_keys[SORT_DEPTH];
        bit [TAG_W-1:0]      order_tags[SORT_DEPTH];
        sorted_rec_t         rec;
        int                  count;
        int                  slot;

        if (held_keys.size() < SORT_DEPTH)
        begin
            held_keys.push_back(key & KEY_MASK[KEY_PORT_W-1:0]);
            held_tags.push_back(tag);
        end
        else
        begin
            batch_dropped = 1'b1;
        end
        if (!closes)
            return;

        // Insertion sort: a key only moves past strictly larger keys, which
        // keeps ties in the order they were loaded.
        count = held_keys.size();
        for (int i = 0; i < count; i++)
        begin
            slot = i;
            while (slot > 0 && order_keys[slot - 1] > held_keys[i])
            begin
                order_keys[slot] = order_keys[slot - 1];
                order_tags[slot] = order_tags[slot - 1];
                slot--;
            end
            order_keys[slot] = held_keys[i];
            order_tags[slot] = held_tags[i];
        end

        for (int i = 0; i < count; i++)
        begin
            rec.key     = order_keys[i];
            rec.tag     = order_tags[i];
            rec.closes  = (i == count - 1);
            rec.dropped = batch_dropped;
            sorted_due.push_back(rec);
        end

        batches_closed++;
        if (batch_dropped)
            batches_dropped++;
        held_keys.delete();
        held_tags.delete();
        batch_dropped = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------

    // An item is taken at an edge where start is high and busy is low. While
    // busy holds an item off, start and the payload stay as they are. Once the
    // item is taken, the next one is offered at once or after a random gap,
    // unless it asks for a quiet run or for the sorter to empty out first.
    always @(posedge clk)
    begin : drive_loads
        bit offer;

        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                absorb_record(sort_key, record_tag, batch_end);
                items_taken++;
            end
            if (!(start && busy))
            begin
                offer = (load_queue.size() != 0);
                if (offer && load_queue[0].settle && sorted_due.size() != 0)
                    offer = 1'b0;
                if (offer && !load_queue[0].hush && $urandom_range(0, 99) < IDLE_PERCENT)
                    offer = 1'b0;
                if (offer)
                begin
                    start      <= 1'b1;
                    sort_key   <= load_queue[0].key;
                    record_tag <= load_queue[0].tag;
                    batch_end  <= load_queue[0].closes;
                    void'(load_queue.pop_front());
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------

    // A result lives for exactly one cycle, so it is taken at every edge at
    // which the strobe is seen high and matched with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        sorted_rec_t want;

        if (rst_n && result_strobe === 1'b1)
        begin
            if (sorted_due.size() == 0)
            begin
                if (faults < REPORT_LIMIT)
                    $display("Unexpected result: key %h tag %0d final %0b overflow %0b",
                             sorted_key, sorted_tag, final_flag, overflow);
                faults++;
            end
            else
            begin
                want = sorted_due.pop_front();
                if (sorted_key !== want.key || sorted_tag !== want.tag ||
                    final_flag !== want.closes || overflow !== want.dropped)
                begin
                    if (faults < REPORT_LIMIT)
                    begin
                        $display({"Mismatch at result %0d: expected key %h tag %0d",
                                  " final %0b overflow %0b"},
                                 results_checked, want.key, want.tag, want.closes,
                                 want.dropped);
                        $display({"                     actual   key %h tag %0d",
                                  " final %0b overflow %0b"},
                                 sorted_key, sorted_tag, final_flag, overflow);
                    end
                    faults++;
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic add_record(bit [KEY_PORT_W-1:0] key, bit [TAG_W-1:0] tag,
                              bit closes, bit hush, bit settle);
        load_item_t item;

        item.key    = key;
        item.tag    = tag;
        item.closes = closes;
        item.hush   = hush;
        item.settle = settle;
        load_queue.push_back(item);
    endtask

    // A whole batch of random records; the last one closes it.
    task automatic add_batch(int count, key_mix_t mix, bit hush, bit settle);
        bit [KEY_PORT_W-1:0] key;

        for (int i = 0; i < count; i++)
        begin
            case (mix)
                KEYS_SPREAD:    key = $urandom();
                // A narrow range gives plenty of ties to test the load order.
                KEYS_CLUSTERED: key = $urandom_range(0, 7);
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       key = '0;
                        1:       key = '1;
                        2:       key = {{(KEY_PORT_W - 1){1'b1}}, 1'b0};
                        3:       key = 1;
                        default: key = $urandom();
                    endcase
                end
            endcase
            add_record(key, TAG_W'($urandom_range(0, 63)), i == count - 1, hush,
                       settle && i == 0);
        end
    endtask

    initial
    begin : run_sequence
        int       loaded;
        int       batch_no;
        int       size;
        key_mix_t mix;

        // Single-record batches at both ends of the key and tag ranges.
        add_record('0, 0, 1'b1, 1'b0, 1'b0);
        add_record('1, 63, 1'b1, 1'b0, 1'b0);

        // Keys in falling order, offered only once the sorter has emptied.
        add_record('1, 1, 1'b0, 1'b0, 1'b1);
        add_record(32'h8000_0000, 2, 1'b0, 1'b0, 1'b0);
        add_record(32'h0000_0001, 4, 1'b0, 1'b0, 1'b0);
        add_record('0, 8, 1'b1, 1'b0, 1'b0);

        // Repeated keys must come out in the order they went in.
        add_record(5, 10, 1'b0, 1'b0, 1'b0);
        add_record(5, 11, 1'b0, 1'b0, 1'b0);
        add_record(3, 12, 1'b0, 1'b0, 1'b0);
        add_record(5, 13, 1'b0, 1'b0, 1'b0);
        add_record(3, 14, 1'b1, 1'b0, 1'b0);

        // Already in order, with duplicated extremes.
        add_record('0, 32, 1'b0, 1'b0, 1'b0);
        add_record('0, 16, 1'b0, 1'b0, 1'b0);
        add_record('1, 63, 1'b0, 1'b0, 1'b0);
        add_record('1, 0, 1'b1, 1'b0, 1'b0);

        // Alternating bit patterns in key and tag.
        add_record(32'hAAAA_AAAA, 21, 1'b0, 1'b0, 1'b0);
        add_record(32'h5555_5555, 42, 1'b1, 1'b0, 1'b0);

        // Random batches, mostly short. One exactly fills the sorter and is
        // loaded back to back together with the batch after it; a later one
        // runs three records past capacity, so its closing record is itself
        // dropped.
        loaded   = 0;
        batch_no = 0;
        while (loaded < RANDOM_ITEMS)
        begin
            if (batch_no == 2)
                size = SORT_DEPTH;
            else if (batch_no == 5)
                size = SORT_DEPTH + 3;
            else
                size = $urandom_range(1, 12);
            mix = key_mix_t'($urandom_range(0, 2));
            add_batch(size, mix, batch_no == 2 || batch_no == 3,
                      batch_no == 0 || $urandom_range(0, 7) == 0);
            loaded += size;
            batch_no++;
        end
        items_total = load_queue.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken != items_total)
            @(posedge clk);
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);

        $display("Loaded %0d records in %0d batches, %0d of them overflowing;",
                 items_taken, batches_closed, batches_dropped);
        $display("checked %0d sorted results, %0d mismatches.", results_checked, faults);
        if (faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Backstop against a hung handshake or results that never arrive.
    initial
    begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d of %0d records taken and %0d results outstanding.",
                 items_taken, items_total, sorted_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
